/* rtl/core/rpn_stack_calculator_macros.svh */
// Assertion macros used by the checker file
`ifndef RPN_STACK_CALCULATOR_MACROS_SVH
`define RPN_STACK_CALCULATOR_MACROS_SVH

`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define RPN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/rpn_pkg.sv */
package rpn_pkg;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = AW + 1;

	typedef enum logic [2:0] {
		FN_PUSH = 3'd0,
		FN_POP  = 3'd1,
		FN_ADD  = 3'd2,
		FN_SUB  = 3'd3,
		FN_MUL  = 3'd4,
		FN_DIV  = 3'd5,
		FN_PKT  = 3'd6,
		FN_PKB  = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FEW   = 3'd2,
		ST_RANGE = 3'd3,
		ST_DIVZ  = 3'd4,
		ST_FULL  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD2,
		S_EXEC,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	// divider control and status
	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;

endpackage

/* rtl/core/rpn_ram.sv */
module rpn_ram #(
	parameter int unsigned DW = 32,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/rpn_div.sv */
// Floor division, one quotient bit a cycle on magnitudes
module rpn_div (
	input  logic             clk,
	input  logic             arst_n,
	input  rpn_pkg::div_req_t req,
	output rpn_pkg::div_rsp_t rsp
);

	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        neg_q;
	logic        fin_q;
	logic [32:0] trial;
	logic [32:0] sub;
	logic [31:0] qmag;

	assign trial = {rem_q[31:0], a_q[31]};
	assign sub = trial - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.num[31] ? -req.num : req.num;
			b_q <= req.den[31] ? -req.den : req.den;
			neg_q <= req.num[31] ^ req.den[31];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[30:0], 1'b0};
			if (!sub[32]) begin
				rem_q <= sub;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// round toward minus infinity when signs differ and a remainder is left
	assign qmag = quo_q + {31'd0, (neg_q && rem_q != '0)};
	assign rsp.done = fin_q;
	assign rsp.quot = neg_q ? -qmag : quo_q;

endmodule

/* rtl/core/rpn_stack_calculator.sv */
// Channel | Beat fields (low bit up)              | Handshake
// s_axis  | func[2:0] value[34:3] index[44:35]    | tvalid/tready
// m_axis  | result[31:0] status[34:32] depth[45:35] | tvalid/tready
// Push, pop and peek go through EXEC; add/sub read twice (RD2, EXEC) on the
// single stack RAM read port, mul adds MUL and divide waits in DIV on the divider.
// One beat is in flight; the result register frees s_axis_tready again
// once m_axis takes the result. Reset clears the state, count and valid flag.
module rpn_stack_calculator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // func, value, index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // result, status, depth
);

	localparam int unsigned AW = rpn_pkg::AW;
	localparam int unsigned CW = rpn_pkg::CW;

	rpn_pkg::state_t state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [2:0]    func_q;
	logic [31:0]   val_q;
	logic [9:0]    idx_q;
	logic [31:0]   d_q;
	logic [31:0]   prod_q;
	logic [31:0]   res_q;
	rpn_pkg::status_t st_q;
	logic          ovalid_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;
	rpn_pkg::div_req_t dreq;
	rpn_pkg::div_rsp_t drsp;
	logic          acc;

	rpn_ram #(.DW(32), .DEPTH(rpn_pkg::DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	rpn_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_axis_tready = (state_q == rpn_pkg::S_IDLE) && !ovalid_q;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {2'b00, cnt_q, st_q, res_q};

	logic fin;
	logic [31:0] fin_res;
	rpn_pkg::status_t fin_st;
	logic [CW-1:0] fin_cnt;

	// read address from accepted beat (top, or the peeked entry) or during RD2 (second from top)
	always_comb begin
		logic [CW-1:0] a;
		a = cnt_q - 1'b1;
		if (state_q == rpn_pkg::S_RD2)
			a = cnt_q - 2'd2;
		else if (acc && s_axis_tdata[2:0] == rpn_pkg::FN_PKT)
			a = cnt_q - 1'b1 - {1'b0, s_axis_tdata[44:35]};
		else if (acc && s_axis_tdata[2:0] == rpn_pkg::FN_PKB)
			a = {1'b0, s_axis_tdata[44:35]};
		raddr = a[AW-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rpn_pkg::S_IDLE:
				if (acc) begin
					if (s_axis_tdata[2:0] inside {rpn_pkg::FN_ADD, rpn_pkg::FN_SUB,
						rpn_pkg::FN_MUL, rpn_pkg::FN_DIV} && cnt_q >= CW'(2))
						state_d = rpn_pkg::S_RD2;
					else
						state_d = rpn_pkg::S_EXEC;
				end
			rpn_pkg::S_RD2: state_d = rpn_pkg::S_EXEC;
			rpn_pkg::S_EXEC:
				if (func_q == rpn_pkg::FN_MUL && cnt_q >= CW'(2))
					state_d = rpn_pkg::S_MUL;
				else if (func_q == rpn_pkg::FN_DIV && cnt_q >= CW'(2) && d_q != '0)
					state_d = rpn_pkg::S_DIV;
				else
					state_d = rpn_pkg::S_IDLE;
			rpn_pkg::S_MUL: state_d = rpn_pkg::S_IDLE;
			rpn_pkg::S_DIV: if (drsp.done) state_d = rpn_pkg::S_IDLE;
			default: state_d = rpn_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		fin = 1'b0;
		fin_res = '0;
		fin_st = rpn_pkg::ST_OK;
		fin_cnt = cnt_q;
		we = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = val_q;
		dreq.start = 1'b0;
		dreq.num = rdata;
		dreq.den = d_q;
		case (state_q)
			rpn_pkg::S_EXEC: begin
				case (func_q)
					rpn_pkg::FN_PUSH: begin
						fin = 1'b1;
						if (cnt_q >= CW'(rpn_pkg::DEPTH))
							fin_st = rpn_pkg::ST_FULL;
						else begin
							we = 1'b1;
							fin_cnt = cnt_q + 1'b1;
						end
					end
					rpn_pkg::FN_POP: begin
						fin = 1'b1;
						if (cnt_q == '0)
							fin_st = rpn_pkg::ST_EMPTY;
						else begin
							fin_res = rdata;
							fin_cnt = cnt_q - 1'b1;
						end
					end
					rpn_pkg::FN_PKT, rpn_pkg::FN_PKB: begin
						fin = 1'b1;
						if ({1'b0, idx_q} >= cnt_q)
							fin_st = rpn_pkg::ST_RANGE;
						else
							fin_res = rdata;
					end
					default: begin
						waddr = AW'(cnt_q - 2'd2);
						if (cnt_q < CW'(2)) begin
							fin = 1'b1;
							fin_st = rpn_pkg::ST_FEW;
						end else if (func_q == rpn_pkg::FN_ADD ||
							func_q == rpn_pkg::FN_SUB) begin
							fin = 1'b1;
							fin_res = (func_q == rpn_pkg::FN_ADD) ? rdata + d_q : rdata - d_q;
							we = 1'b1;
							wdata = fin_res;
							fin_cnt = cnt_q - 1'b1;
						end else if (func_q == rpn_pkg::FN_DIV) begin
							if (d_q == '0) begin
								fin = 1'b1;
								fin_st = rpn_pkg::ST_DIVZ;
							end else
								dreq.start = 1'b1;
						end
					end
				endcase
			end
			rpn_pkg::S_MUL: begin
				waddr = AW'(cnt_q - 2'd2);
				fin = 1'b1;
				fin_res = prod_q;
				we = 1'b1;
				wdata = prod_q;
				fin_cnt = cnt_q - 1'b1;
			end
			rpn_pkg::S_DIV: begin
				waddr = AW'(cnt_q - 2'd2);
				wdata = drsp.quot;
				if (drsp.done) begin
					fin = 1'b1;
					fin_res = drsp.quot;
					we = 1'b1;
					fin_cnt = cnt_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpn_pkg::S_IDLE;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= fin_cnt;
			if (fin)
				ovalid_q <= 1'b1;
			else if (m_axis_tready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			func_q <= s_axis_tdata[2:0];
			val_q <= s_axis_tdata[34:3];
			idx_q <= s_axis_tdata[44:35];
		end
		// hold top operand while the second read is in flight
		if (state_q == rpn_pkg::S_RD2)
			d_q <= rdata;
		if (state_q == rpn_pkg::S_EXEC)
			prod_q <= rdata * d_q;
		if (fin) begin
			res_q <= fin_res;
			st_q <= fin_st;
		end
	end

endmodule

/* rtl/core/rpn_checker.sv */
`include "rpn_stack_calculator_macros.svh"

module rpn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	`RPN_ASSERT_IMP(a_one_in_flight, clk, arst_n, m_axis_tvalid, !s_axis_tready, "ready while result pending")
	`RPN_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
	`RPN_ASSERT_IMP(a_status, clk, arst_n, m_axis_tvalid, m_axis_tdata[34:32] <= rpn_pkg::ST_FULL, "bad status")
	`RPN_ASSERT_IMP(a_err_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[34:32] != rpn_pkg::ST_OK, m_axis_tdata[31:0] == '0, "error with nonzero result")
	`RPN_ASSERT_IMP(a_depth, clk, arst_n, m_axis_tvalid, m_axis_tdata[45:35] <= 11'(rpn_pkg::DEPTH), "depth beyond limit")

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
